// File: sv/mths_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mechanism token header strip block
// no dependencies

package mths_pkg;

  localparam int unsigned LENGTH_BITS_DEF   = 32;
  localparam int unsigned MAX_OID_BYTES_DEF = 16;
  localparam int unsigned RES_FIFO_DEPTH    = 4;

  localparam int unsigned OID_LEN_W   = 5;
  localparam int unsigned OID_STORE_W = 64;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [7:0] OUTER_TAG      = 8'h60;
  localparam logic [7:0] OID_TAG        = 8'h06;
  localparam logic [7:0] LONG_FORM      = 8'h80;
  localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;

  typedef enum logic [1:0] {
    REG_OID_LEN  = 2'd0,
    REG_OID_LOW  = 2'd1,
    REG_OID_HIGH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_OUTER     = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_MORE  = 3'd2,
    PH_OID_TAG   = 3'd3,
    PH_OID_LEN   = 3'd4,
    PH_OID_BODY  = 3'd5,
    PH_PAYLOAD   = 3'd6,
    PH_DRAIN     = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_DEFECT   = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [OID_LEN_W-1:0]   oid_len;
    logic [OID_STORE_W-1:0] oid_low;
    logic [OID_STORE_W-1:0] oid_high;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    status_e    status;
    logic       final_res;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// File: sv/mths_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for token bytes in and result words out
// no dependencies

interface mths_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       token_end;

  modport source (output valid, output token_byte, output token_end, input ready);
  modport sink   (input valid, input token_byte, input token_end, output ready);
endinterface

interface mths_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [1:0] status;
  logic       final_res;

  modport source (output valid, output kind, output payload_byte, output status,
                  output final_res, input ready);
  modport sink   (input valid, input kind, input payload_byte, input status,
                  input final_res, output ready);
endinterface

// File: sv/mech_token_header_strip_core.sv
`timescale 1ns / 1ps
// top level of the mechanism token header strip block
// depends on mths_pkg, mths_if, mths_cfg_regs, mths_parser, mths_res_fifo
//
// usage:
// tok_i carries one token byte per word, token_end set on the last byte.
// res_o carries result words: payload bytes found after the oid while the
// oid matches (kind 0), and one status word (kind 1, final_res set) for
// the last byte of each token, after that byte's payload word if any.
// the apb port writes expected oid length (0x00), oid bytes 0-7 (0x08) and
// oid bytes 8-15 (0x10); write only while no token byte is in flight.
// a result word passes through the input register and the result queue
// before it is valid on res_o.
// throughput: one byte per cycle while the queue has room; a last byte with
// a payload word pushes two words, absorbed by the four-word result queue.
// the parser state updates from the input register as each byte leaves it.
// reset clears the parser to wait for an outer tag, empties the queue and
// zeroes the registers. when the receiver stalls, words collect in the
// queue; tok_i.ready drops with a byte held and fewer than two slots free.

module mech_token_header_strip_core #(
  parameter int unsigned LENGTH_BITS   = mths_pkg::LENGTH_BITS_DEF,
  parameter int unsigned MAX_OID_BYTES = mths_pkg::MAX_OID_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mths_tok_if.sink                        tok_i,
  mths_res_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mths_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mths_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mths_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  mths_pkg::cfg_t  cfg;
  mths_pkg::push_t push;
  logic            room;

  mths_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mths_parser #(
    .LENGTH_BITS   (LENGTH_BITS),
    .MAX_OID_BYTES (MAX_OID_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_i),
    .cfg_i  (cfg),
    .room_i (room),
    .push_o (push)
  );

  mths_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

// File: sv/mths_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file holding the expected mechanism oid
// depends on mths_pkg

module mths_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mths_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mths_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mths_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output mths_pkg::cfg_t                  cfg_o
);

  mths_pkg::cfg_t   cfg_q, cfg_d;
  mths_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = mths_pkg::reg_idx_e'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        mths_pkg::REG_OID_LEN:  cfg_d.oid_len  = pwdata[mths_pkg::OID_LEN_W-1:0];
        mths_pkg::REG_OID_LOW:  cfg_d.oid_low  = pwdata;
        mths_pkg::REG_OID_HIGH: cfg_d.oid_high = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mths_pkg::REG_OID_LEN:  prdata = mths_pkg::CFG_DATA_W'(cfg_q.oid_len);
      mths_pkg::REG_OID_LOW:  prdata = cfg_q.oid_low;
      mths_pkg::REG_OID_HIGH: prdata = cfg_q.oid_high;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/mths_parser.sv
`timescale 1ns / 1ps
// input register and header parser: tag, der length, oid compare, payload pass
// depends on mths_pkg and mths_tok_if

module mths_parser #(
  parameter int unsigned LENGTH_BITS   = mths_pkg::LENGTH_BITS_DEF,
  parameter int unsigned MAX_OID_BYTES = mths_pkg::MAX_OID_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mths_tok_if.sink        tok_i,
  input  mths_pkg::cfg_t  cfg_i,
  input  logic            room_i,
  output mths_pkg::push_t push_o
);

  logic       st_valid_q, st_valid_d;
  logic [7:0] byte_q;
  logic       end_q;
  logic       fire;

  mths_pkg::phase_e phase_q, phase_n, phase_d;
  logic [6:0]             lbl_q, lbl_n, lbl_d;
  logic [LENGTH_BITS-1:0] decl_q, decl_n, decl_d;
  logic [LENGTH_BITS-1:0] bal_q, bal_n, bal_d;
  logic [6:0]             obl_q, obl_n, obl_d;
  logic [6:0]             pos_q, pos_n, pos_d;
  logic                   mism_q, mism_n, mism_d;
  logic                   defect_q, defect_n, defect_d;

  logic [2*mths_pkg::OID_STORE_W-1:0] oid_all;
  logic [7:0]                         exp_byte;
  mths_pkg::res_t                     pay_res, stat_res;
  mths_pkg::status_e                  stat;
  logic                               send_pay;

  assign fire        = st_valid_q && room_i;
  assign tok_i.ready = !st_valid_q || room_i;
  assign st_valid_d  = (tok_i.valid && tok_i.ready) ? 1'b1 : (fire ? 1'b0 : st_valid_q);

  assign oid_all  = {cfg_i.oid_high, cfg_i.oid_low};
  assign exp_byte = oid_all[{pos_q[3:0], 3'b000} +: 8];

  // next state
  always_comb begin
    phase_n  = phase_q;
    lbl_n    = lbl_q;
    decl_n   = decl_q;
    bal_n    = bal_q;
    obl_n    = obl_q;
    pos_n    = pos_q;
    mism_n   = mism_q;
    defect_n = defect_q;

    if (phase_q >= mths_pkg::PH_OID_TAG && phase_q <= mths_pkg::PH_PAYLOAD && bal_q != '1) begin
      bal_n = bal_q + LENGTH_BITS'(1);
    end

    unique case (phase_q)
      mths_pkg::PH_OUTER: begin
        if (byte_q == mths_pkg::OUTER_TAG) begin
          phase_n = mths_pkg::PH_LEN_FIRST;
        end else begin
          defect_n = 1'b1;
          phase_n  = mths_pkg::PH_DRAIN;
        end
      end
      mths_pkg::PH_LEN_FIRST: begin
        if ((byte_q & mths_pkg::LONG_FORM) == '0) begin
          decl_n  = LENGTH_BITS'(byte_q);
          phase_n = mths_pkg::PH_OID_TAG;
        end else begin
          lbl_n   = byte_q[6:0];
          decl_n  = '0;
          phase_n = (byte_q[6:0] == '0) ? mths_pkg::PH_OID_TAG : mths_pkg::PH_LEN_MORE;
        end
      end
      mths_pkg::PH_LEN_MORE: begin
        if (decl_q[LENGTH_BITS-1 -: 8] != '0) begin
          defect_n = 1'b1;
          phase_n  = mths_pkg::PH_DRAIN;
        end else begin
          decl_n = {decl_q[LENGTH_BITS-9:0], byte_q};
          lbl_n  = lbl_q - 7'd1;
          if (lbl_q == 7'd1) begin
            phase_n = mths_pkg::PH_OID_TAG;
          end
        end
      end
      mths_pkg::PH_OID_TAG: begin
        if (byte_q == mths_pkg::OID_TAG) begin
          phase_n = mths_pkg::PH_OID_LEN;
        end else begin
          defect_n = 1'b1;
          phase_n  = mths_pkg::PH_DRAIN;
        end
      end
      mths_pkg::PH_OID_LEN: begin
        if ((byte_q & mths_pkg::LONG_FORM) != '0) begin
          defect_n = 1'b1;
          phase_n  = mths_pkg::PH_DRAIN;
        end else begin
          obl_n   = byte_q[6:0];
          pos_n   = '0;
          mism_n  = (byte_q != 8'(cfg_i.oid_len));
          phase_n = (byte_q == '0) ? mths_pkg::PH_PAYLOAD : mths_pkg::PH_OID_BODY;
        end
      end
      mths_pkg::PH_OID_BODY: begin
        if (pos_q >= 7'(MAX_OID_BYTES) || byte_q != exp_byte) begin
          mism_n = 1'b1;
        end
        pos_n = pos_q + 7'd1;
        obl_n = obl_q - 7'd1;
        if (obl_q == 7'd1) begin
          phase_n = mths_pkg::PH_PAYLOAD;
        end
      end
      mths_pkg::PH_PAYLOAD, mths_pkg::PH_DRAIN: ;
    endcase

    if (fire && end_q) begin
      phase_d  = mths_pkg::PH_OUTER;
      lbl_d    = '0;
      decl_d   = '0;
      bal_d    = '0;
      obl_d    = '0;
      pos_d    = '0;
      mism_d   = 1'b0;
      defect_d = 1'b0;
    end else if (fire) begin
      phase_d  = phase_n;
      lbl_d    = lbl_n;
      decl_d   = decl_n;
      bal_d    = bal_n;
      obl_d    = obl_n;
      pos_d    = pos_n;
      mism_d   = mism_n;
      defect_d = defect_n;
    end else begin
      phase_d  = phase_q;
      lbl_d    = lbl_q;
      decl_d   = decl_q;
      bal_d    = bal_q;
      obl_d    = obl_q;
      pos_d    = pos_q;
      mism_d   = mism_q;
      defect_d = defect_q;
    end
  end

  // result words
  always_comb begin
    send_pay = (phase_q == mths_pkg::PH_PAYLOAD) && !mism_q;

    if (defect_n || phase_n != mths_pkg::PH_PAYLOAD || bal_n == '1 || bal_n != decl_n) begin
      stat = mths_pkg::ST_DEFECT;
    end else if (mism_n) begin
      stat = mths_pkg::ST_MISMATCH;
    end else begin
      stat = mths_pkg::ST_COMPLETE;
    end

    pay_res.kind          = mths_pkg::KIND_PAYLOAD;
    pay_res.payload_byte  = byte_q;
    pay_res.status        = mths_pkg::ST_COMPLETE;
    pay_res.final_res     = 1'b0;
    stat_res.kind         = mths_pkg::KIND_STATUS;
    stat_res.payload_byte = '0;
    stat_res.status       = stat;
    stat_res.final_res    = 1'b1;

    push_o.cnt    = 2'd0;
    push_o.first  = pay_res;
    push_o.second = stat_res;
    if (fire) begin
      if (send_pay) begin
        push_o.cnt = end_q ? 2'd2 : 2'd1;
      end else if (end_q) begin
        push_o.cnt   = 2'd1;
        push_o.first = stat_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid && tok_i.ready) begin
      byte_q <= tok_i.token_byte;
      end_q  <= tok_i.token_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      phase_q    <= mths_pkg::PH_OUTER;
      lbl_q      <= '0;
      decl_q     <= '0;
      bal_q      <= '0;
      obl_q      <= '0;
      pos_q      <= '0;
      mism_q     <= 1'b0;
      defect_q   <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
      phase_q    <= phase_d;
      lbl_q      <= lbl_d;
      decl_q     <= decl_d;
      bal_q      <= bal_d;
      obl_q      <= obl_d;
      pos_q      <= pos_d;
      mism_q     <= mism_d;
      defect_q   <= defect_d;
    end
  end

endmodule

// File: sv/mths_res_fifo.sv
`timescale 1ns / 1ps
// small result queue taking up to two words per cycle, one out per handshake
// depends on mths_pkg and mths_res_if

module mths_res_fifo #(
  parameter int unsigned DEPTH = mths_pkg::RES_FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mths_pkg::push_t push_i,
  output logic            room_o,
  mths_res_if.source      res_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mths_pkg::res_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  mths_pkg::res_t   head;

  assign head    = mem_q[rd_q];
  assign pop     = res_o.valid && res_o.ready;
  assign room_o  = cnt_q <= CNT_W'(DEPTH - 2);
  assign wr_next = wr_q + PTR_W'(1);
  assign wr_d    = wr_q + PTR_W'(push_i.cnt);
  assign rd_d    = rd_q + PTR_W'(pop);
  assign cnt_d   = cnt_q + CNT_W'(push_i.cnt) - CNT_W'(pop);

  assign res_o.valid        = cnt_q != '0;
  assign res_o.kind         = head.kind;
  assign res_o.payload_byte = head.payload_byte;
  assign res_o.status       = head.status;
  assign res_o.final_res    = head.final_res;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for mech_token_header_strip_core, with its own model of the token parser
// depends on mths_pkg, mths_if and the core; directed tokens, then random ones under varied oid setup

module tb;
  import mths_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {CUT_SHORT, HIT_HEADER, JUNK} spoil_e;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned LEN_W = LENGTH_BITS_DEF;

  logic clk = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  mths_tok_if tok ();
  mths_res_if res ();

  mech_token_header_strip_core i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .tok_i   (tok),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // model copy of the configuration and the parser state
  logic [OID_LEN_W-1:0]   cfg_oid_len;
  logic [OID_STORE_W-1:0] cfg_oid_low, cfg_oid_high;
  phase_e                 hdr_phase;
  logic [6:0]             len_left, oid_left, oid_pos;
  logic [LEN_W-1:0]       decl_len, after_len;
  logic                   oid_bad, defect;

  res_t pending_words[$];
  res_t head_word;
  int   err_count = 0;
  int   word_count = 0;
  int   bytes_sent = 0;
  bit   src_steady = 1'b0;
  bit   sink_steady = 1'b0;
  bit   hold_on = 1'b0;
  event hold_go;

  function automatic bit gap_roll();
    return $urandom_range(0, 99) < 22;
  endfunction

  function automatic void clear_token();
    hdr_phase = PH_OUTER;
    len_left  = '0;
    decl_len  = '0;
    after_len = '0;
    oid_left  = '0;
    oid_pos   = '0;
    oid_bad   = 1'b0;
    defect    = 1'b0;
  endfunction

  function automatic void mark_defect();
    defect    = 1'b1;
    hdr_phase = PH_DRAIN;
  endfunction

  // one token byte through the parser model, queuing the words it yields
  function automatic void strip_byte(input logic [7:0] b, input logic last);
    logic [127:0] oid_all;
    status_e st;
    oid_all = {cfg_oid_high, cfg_oid_low};
    if (hdr_phase >= PH_OID_TAG && hdr_phase <= PH_PAYLOAD && after_len != '1)
      after_len = after_len + 1'b1;
    case (hdr_phase)
      PH_OUTER: begin
        if (b == OUTER_TAG) hdr_phase = PH_LEN_FIRST;
        else mark_defect();
      end
      PH_LEN_FIRST: begin
        if ((b & LONG_FORM) == 8'h00) begin
          decl_len  = LEN_W'(b);
          hdr_phase = PH_OID_TAG;
        end else begin
          len_left  = 7'(b & LEN_COUNT_MASK);
          decl_len  = '0;
          hdr_phase = (len_left == 0) ? PH_OID_TAG : PH_LEN_MORE;
        end
      end
      PH_LEN_MORE: begin
        if (decl_len[LEN_W-1 -: 8] != 8'h00) begin
          mark_defect();
        end else begin
          decl_len = {decl_len[LEN_W-9:0], b};
          len_left = len_left - 1'b1;
          if (len_left == 0) hdr_phase = PH_OID_TAG;
        end
      end
      PH_OID_TAG: begin
        if (b == OID_TAG) hdr_phase = PH_OID_LEN;
        else mark_defect();
      end
      PH_OID_LEN: begin
        if ((b & LONG_FORM) != 8'h00) begin
          mark_defect();
        end else begin
          oid_left  = b[6:0];
          oid_pos   = '0;
          oid_bad   = (b != 8'(cfg_oid_len));
          hdr_phase = (b == 8'h00) ? PH_PAYLOAD : PH_OID_BODY;
        end
      end
      PH_OID_BODY: begin
        if (oid_pos >= MAX_OID_BYTES_DEF) oid_bad = 1'b1;
        else if (b != oid_all[8*oid_pos +: 8]) oid_bad = 1'b1;
        oid_pos  = oid_pos + 1'b1;
        oid_left = oid_left - 1'b1;
        if (oid_left == 0) hdr_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (!oid_bad)
          pending_words.push_back('{kind: KIND_PAYLOAD, payload_byte: b,
                                    status: ST_COMPLETE, final_res: 1'b0});
      end
      default: ;
    endcase
    if (last) begin
      if (defect || hdr_phase != PH_PAYLOAD || after_len == '1 || after_len != decl_len)
        st = ST_DEFECT;
      else if (oid_bad)
        st = ST_MISMATCH;
      else
        st = ST_COMPLETE;
      pending_words.push_back('{kind: KIND_STATUS, payload_byte: 8'h00,
                                status: st, final_res: 1'b1});
      clear_token();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_count++;
    if (err_count <= 40)
      $display("%0t word %0d: %s got %0h want %0h", $time, word_count, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_ni && res.valid && res.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, kind", 8'(res.kind), 8'h00);
      end else begin
        head_word = pending_words.pop_front();
        if (res.kind !== head_word.kind)
          report_mismatch("kind", 8'(res.kind), 8'(head_word.kind));
        if (res.payload_byte !== head_word.payload_byte)
          report_mismatch("payload_byte", res.payload_byte, head_word.payload_byte);
        if (res.status !== head_word.status)
          report_mismatch("status", 8'(res.status), 8'(head_word.status));
        if (res.final_res !== head_word.final_res)
          report_mismatch("final_res", 8'(res.final_res), 8'(head_word.final_res));
      end
      word_count++;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_on) res.ready <= 1'b0;
    else res.ready <= sink_steady || !gap_roll();
  end

  // long receiver hold-off, counted in cycles
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!src_steady && gap_roll()) begin
      tok.valid <= 1'b0;
      @(negedge clk);
    end
    tok.valid      <= 1'b1;
    tok.token_byte <= b;
    tok.token_end  <= last;
    @(posedge clk);
    while (!tok.ready) @(posedge clk);
    strip_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_token(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    tok.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OID_LEN:  cfg_oid_len  = data[OID_LEN_W-1:0];
      REG_OID_LOW:  cfg_oid_low  = data;
      REG_OID_HIGH: cfg_oid_high = data;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // well-formed token around the configured oid, with optional skew of the declared length
  function automatic void build_token(output byte_q_t q, input int oid_n, input bit oid_match,
                                      input int pay_n, input int len_bytes, input int skew);
    logic [127:0] oid_all;
    logic [LEN_W-1:0] decl;
    logic [7:0] ob;
    int total, nb, i, bad_pos;
    q = {};
    oid_all = {cfg_oid_high, cfg_oid_low};
    total = 2 + oid_n + pay_n + skew;
    if (total < 0) total = 0;
    decl = LEN_W'(total);
    q.push_back(OUTER_TAG);
    if (len_bytes == 0 && decl < 128) begin
      q.push_back(decl[7:0]);
    end else begin
      nb = len_bytes;
      while (nb < 4 && (decl >> (8 * nb)) != 0) nb++;
      q.push_back(LONG_FORM | 8'(nb));
      for (i = nb - 1; i >= 0; i--) q.push_back(i < 4 ? decl[8*i +: 8] : 8'h00);
    end
    q.push_back(OID_TAG);
    q.push_back(8'(oid_n));
    bad_pos = oid_match ? -1 : ((oid_n > 0) ? int'($urandom_range(0, oid_n - 1)) : -1);
    for (i = 0; i < oid_n; i++) begin
      ob = (i < MAX_OID_BYTES_DEF) ? oid_all[8*i +: 8] : 8'($urandom_range(0, 255));
      if (i == bad_pos) ob = ob ^ (8'h01 << $urandom_range(0, 7));
      q.push_back(ob);
    end
    repeat (pay_n) q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic random_tokens(input int n);
    byte_q_t q;
    int start, oid_n, pay_n, len_bytes, skew, k;
    spoil_e spoil;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      k = $urandom_range(0, 99);
      oid_n = (k < 70) ? int'(cfg_oid_len) :
              (k < 98) ? int'($urandom_range(0, 18)) : int'($urandom_range(19, 127));
      pay_n = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      len_bytes = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 6);
      skew = 0;
      if ($urandom_range(0, 99) < 15)
        skew = $urandom_range(0, 1) ? -int'($urandom_range(1, 3)) : int'($urandom_range(1, 3));
      build_token(q, oid_n, $urandom_range(0, 99) < 85, pay_n, len_bytes, skew);
      if ($urandom_range(0, 99) < 12) begin
        spoil = spoil_e'($urandom_range(0, 2));
        case (spoil)
          CUT_SHORT: begin
            k = $urandom_range(1, q.size() - 1);
            q = q[0:k-1];
          end
          HIT_HEADER: begin
            k = $urandom_range(0, q.size() - pay_n - 1);
            q[k] = q[k] ^ 8'($urandom_range(1, 255));
          end
          default: begin
            q = {};
            repeat ($urandom_range(1, 5)) q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      send_token(q);
      if ($urandom_range(0, 99) < 4) wait_drained();
    end
  endtask

  task automatic test_bad_tags();
    send_token('{8'h00});
    send_token('{OUTER_TAG, 8'h02, 8'h07, 8'h00});
  endtask

  task automatic test_truncated();
    send_token('{OUTER_TAG});
    send_token('{OUTER_TAG, LONG_FORM, OID_TAG, 8'h00});
  endtask

  task automatic test_long_oid_len();
    send_token('{OUTER_TAG, 8'h02, OID_TAG, LONG_FORM | 8'h01});
  endtask

  task automatic test_empty_oid();
    send_token('{OUTER_TAG, 8'h04, OID_TAG, 8'h00, 8'h00, 8'hff});
  endtask

  task automatic test_length_overflow();
    send_token('{OUTER_TAG, LONG_FORM | 8'h05, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
  endtask

  task automatic test_oid_all_ones();
    wait_drained();
    cfg_write(REG_OID_LEN, 64'(MAX_OID_BYTES_DEF));
    cfg_write(REG_OID_LOW, '1);
    cfg_write(REG_OID_HIGH, '1);
    random_tokens(90);
  endtask

  task automatic test_oid_random();
    wait_drained();
    cfg_write(REG_OID_LEN, {$urandom, $urandom});
    cfg_write(REG_OID_LEN, 64'($urandom_range(1, 15)));
    cfg_write(REG_OID_LOW, {$urandom, $urandom});
    cfg_write(REG_OID_HIGH, {$urandom, $urandom});
    random_tokens(90);
  endtask

  task automatic test_no_gaps();
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    random_tokens(80);
    wait_drained();
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_full_queue();
    byte_q_t q;
    int start;
    start = bytes_sent;
    -> hold_go;
    while (bytes_sent - start < 60) begin
      build_token(q, cfg_oid_len, 1'b1, 10, 0, 0);
      send_token(q);
    end
    wait_drained();
  endtask

  task automatic test_oid_oversize();
    wait_drained();
    cfg_write(REG_OID_LEN, {{(CFG_DATA_W-OID_LEN_W){1'b1}}, {OID_LEN_W{1'b1}}});
    cfg_write(REG_OID_LOW, '0);
    cfg_write(REG_OID_HIGH, '0);
    cfg_write(REG_SPARE, '1);
    random_tokens(60);
  endtask

  task automatic test_oid_zero();
    wait_drained();
    cfg_write(REG_OID_LEN, '0);
    random_tokens(50);
  endtask

  initial begin
    rst_ni         = 1'b0;
    tok.valid      = 1'b0;
    tok.token_byte = 8'h00;
    tok.token_end  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_oid_len    = '0;
    cfg_oid_low    = '0;
    cfg_oid_high   = '0;
    clear_token();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    test_bad_tags();
    test_truncated();
    test_long_oid_len();
    test_empty_oid();
    test_length_overflow();
    test_oid_all_ones();
    test_oid_random();
    test_no_gaps();
    test_full_queue();
    test_oid_oversize();
    test_oid_zero();
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: mech_token_header_strip_core.f
sv/mths_pkg.sv
sv/mths_if.sv
sv/mths_cfg_regs.sv
sv/mths_parser.sv
sv/mths_res_fifo.sv
sv/mech_token_header_strip_core.sv
tb/sv/tb.sv
